>>> src/pixel_format_to_xrgb_converter_macros.svh
// ----------------------------------------------------------------------------
// Pixel format converter assertion macros
// Shared property templates for the converter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_TO_XRGB_CONVERTER_MACROS_SVH
`define PIXEL_FORMAT_TO_XRGB_CONVERTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFXC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfxc assertion failed");

// next-cycle implication, disabled during reset
`define PFXC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfxc assertion failed");

`endif

>>> src/pfxc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel format converter package
// Format codes, command codes, register indexes and per-format conversions
// ----------------------------------------------------------------------------
package pfxc_pkg;

    localparam int ADDR_W = 3;

    typedef enum logic [2:0] {
        FMT_XRGB    = 3'd0,
        FMT_RGB565  = 3'd1,
        FMT_XRGB1555 = 3'd2,
        FMT_ARGB4444 = 3'd3,
        FMT_RGB332  = 3'd4,
        FMT_PALETTE = 3'd5,
        FMT_GRAY4   = 3'd6,
        FMT_MONO    = 3'd7
    } fmt_t;

    typedef enum logic {
        CMD_CONVERT       = 1'b0,
        CMD_PALETTE_WRITE = 1'b1
    } cmd_t;

    localparam logic REG_COLOR_FORMAT = 1'b0;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
    localparam logic [31:0] MONO_WHITE   = 32'hffffffff;
    localparam logic [31:0] MONO_BLACK   = 32'h00000000;
    localparam logic [3:0]  GRAY_PER_BYTE = 4'd2;
    localparam logic [3:0]  MONO_PER_BYTE = 4'd8;

    function automatic logic [31:0] conv_565(input logic [15:0] w);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {w[15:11], {3{w[11]}}};
        g = {w[10:5], {2{w[5]}}};
        b = {w[4:0], {3{w[0]}}};
        return {ALPHA_OPAQUE, r, g, b};
    endfunction

    // green keeps a zero in bit 2 and fills only the two low bits
    function automatic logic [31:0] conv_1555(input logic [15:0] w);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {w[14:10], {3{w[10]}}};
        g = {w[9:5], 1'b0, {2{w[5]}}};
        b = {w[4:0], {3{w[0]}}};
        return {ALPHA_OPAQUE, r, g, b};
    endfunction

    function automatic logic [31:0] conv_4444(input logic [15:0] w);
        return {ALPHA_OPAQUE, w[11:8], w[11:8], w[7:4], w[7:4], w[3:0], w[3:0]};
    endfunction

    function automatic logic [31:0] conv_332(input logic [7:0] w);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {w[7:5], {5{w[5]}}};
        g = {w[4:2], {5{w[2]}}};
        b = {w[1:0], {6{w[0]}}};
        return {ALPHA_OPAQUE, r, g, b};
    endfunction

    function automatic logic [31:0] gray_pixel(input logic [7:0] w, input logic [2:0] pos);
        logic [3:0] n;
        n = (pos == 3'd0) ? w[7:4] : w[3:0];
        return {ALPHA_OPAQUE, n, n, n, n, n, n};
    endfunction

    function automatic logic [31:0] mono_pixel(input logic [7:0] w, input logic [2:0] pos);
        return w[~pos] ? MONO_WHITE : MONO_BLACK;
    endfunction

endpackage

>>> src/pixel_format_to_xrgb_converter.sv
// ----------------------------------------------------------------------------
// Pixel format to XRGB converter
// Turns canvas pixel words into 32-bit XRGB under a configured source format
// ----------------------------------------------------------------------------
// usage:
// - input channel s_*: one transaction per source word or palette write
// - result channel m_*: one transaction per converted pixel, last_pixel marks
//   the final pixel of its input transaction
// - color_format is set over the APB port while no transaction is in flight
// - a pixel passes the input stage register, then the output register
// - throughput: 1 input transaction per cycle for unpacked formats while the
//   receiver does not stall; a packed gray or mono byte holds the input stage
//   until its last pixel is out, handing one pixel per cycle to a free output
//   register; palette writes and packed bytes giving no pixel emit nothing
// - the palette is a single-port-write memory with a registered read taken
//   when the source word is accepted; entries must be written before use
// - reset clears the format to pass-through and empties both stages; the
//   palette contents are not cleared
// - when the receiver stalls, the output register holds its pixel and the
//   input stage keeps one more transaction before s_ready drops
// ----------------------------------------------------------------------------
`include "pixel_format_to_xrgb_converter_macros.svh"

module pixel_format_to_xrgb_converter
    import pfxc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [31:0]         s_source_word,
    input  logic [2:0]          s_start_offset,
    input  logic [3:0]          s_pixel_count,
    input  logic [7:0]          s_palette_index,
    input  logic [31:0]         s_palette_color,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_pixel_xrgb,
    output logic                m_last_pixel
);

    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    fmt_t        color_format_reg;
    logic        cfg_write;

    logic [31:0] pal_mem [PALETTE_ENTRIES];
    logic [31:0] pal_rd_reg;
    logic        pal_we;
    logic        pal_rd_oor;

    logic        s_accept;
    logic        is_packed;
    logic        start_ok;
    logic        empty_next;
    logic [3:0]  per_byte;
    logic [3:0]  left;
    logic [3:0]  eff_count;
    logic [3:0]  last_sum;
    logic [2:0]  pos_next;
    logic [2:0]  last_pos_next;

    logic        a_valid_reg;
    logic        a_empty_reg;
    logic [31:0] a_word_reg;
    logic [2:0]  a_pos_reg;
    logic [2:0]  a_last_pos_reg;
    logic        a_pal_oor_reg;
    logic        a_is_last;
    logic        a_emit;
    logic        a_advance;
    logic [31:0] a_pixel;
    logic        out_free;

    logic        m_valid_reg;
    logic [31:0] m_pixel_reg;
    logic        m_last_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_format_reg <= FMT_XRGB;
        end else if (cfg_write && (paddr[2] == REG_COLOR_FORMAT)) begin
            color_format_reg <= fmt_t'(pwdata[2:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_COLOR_FORMAT) begin
            prdata[2:0] = color_format_reg;
        end
    end

    // input stage control
    assign out_free  = !m_valid_reg || m_ready;
    assign a_is_last = (a_pos_reg == a_last_pos_reg);
    assign a_emit    = a_valid_reg && !a_empty_reg && out_free;
    assign a_advance = a_valid_reg && (a_empty_reg || (out_free && a_is_last));
    assign s_ready   = !a_valid_reg || a_advance;
    assign s_accept  = s_valid && s_ready;

    // packed range and clipping
    always_comb begin
        is_packed = (color_format_reg == FMT_GRAY4) || (color_format_reg == FMT_MONO);
        per_byte  = (color_format_reg == FMT_GRAY4) ? GRAY_PER_BYTE : MONO_PER_BYTE;
        start_ok  = (color_format_reg == FMT_MONO) || (s_start_offset[2:1] == 2'b00);
        left      = per_byte - {1'b0, s_start_offset};
        eff_count = (s_pixel_count > left) ? left : s_pixel_count;
        last_sum  = {1'b0, s_start_offset} + eff_count - 4'd1;
        empty_next = (s_command == CMD_PALETTE_WRITE) ||
                     (is_packed && (!start_ok || (s_pixel_count == 4'd0)));
        if (is_packed) begin
            pos_next      = s_start_offset;
            last_pos_next = last_sum[2:0];
        end else begin
            pos_next      = 3'd0;
            last_pos_next = 3'd0;
        end
    end

    // palette memory
    assign pal_we     = s_accept && (s_command == CMD_PALETTE_WRITE) &&
                        ({1'b0, s_palette_index} < 9'(PALETTE_ENTRIES));
    assign pal_rd_oor = !({1'b0, s_source_word[7:0]} < 9'(PALETTE_ENTRIES));

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[s_palette_index[PAL_AW-1:0]] <= s_palette_color;
        end
        if (s_accept) begin
            pal_rd_reg <= pal_mem[s_source_word[PAL_AW-1:0]];
        end
    end

    // input stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_empty_reg    <= empty_next;
            a_word_reg     <= s_source_word;
            a_pos_reg      <= pos_next;
            a_last_pos_reg <= last_pos_next;
            a_pal_oor_reg  <= pal_rd_oor;
        end else if (a_emit) begin
            a_pos_reg <= a_pos_reg + 3'd1;
        end
    end

    // conversion
    always_comb begin
        case (color_format_reg)
            FMT_XRGB:     a_pixel = a_word_reg;
            FMT_RGB565:   a_pixel = conv_565(a_word_reg[15:0]);
            FMT_XRGB1555: a_pixel = conv_1555(a_word_reg[15:0]);
            FMT_ARGB4444: a_pixel = conv_4444(a_word_reg[15:0]);
            FMT_RGB332:   a_pixel = conv_332(a_word_reg[7:0]);
            FMT_PALETTE:  a_pixel = a_pal_oor_reg ? 32'd0 : pal_rd_reg;
            FMT_GRAY4:    a_pixel = gray_pixel(a_word_reg[7:0], a_pos_reg);
            FMT_MONO:     a_pixel = mono_pixel(a_word_reg[7:0], a_pos_reg);
            default:      a_pixel = a_word_reg;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_emit) begin
            m_pixel_reg <= a_pixel;
            m_last_reg  <= a_is_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_xrgb = m_pixel_reg;
    assign m_last_pixel = m_last_reg;

    // checks
    `PFXC_ASSERT_SAME(a_pos_in_range, aclk, aresetn,
        a_valid_reg && !a_empty_reg, a_pos_reg <= a_last_pos_reg)
    `PFXC_ASSERT_SAME(last_retires_item, aclk, aresetn,
        a_emit && a_is_last, a_advance && s_ready)
    `PFXC_ASSERT_NEXT(stall_holds_stage, aclk, aresetn,
        a_valid_reg && !a_advance && !s_accept, a_valid_reg && $stable(a_word_reg))

endmodule
